/* hdl/spa_pkg.sv */
// ----------------------------------------------------------------------------
// Sine polynomial approximation package
// Shared widths, fixed-point constants and helper functions for the sine
// unit and its submodules.
// ----------------------------------------------------------------------------
package spa_pkg;

   // Default width of the incoming angle (Q4.27 at 32 bits).
   localparam int DEFAULT_ANGLE_WIDTH = 32;

   // Integer bits of the angle format, sign included.
   localparam int ANGLE_INT_BITS = 5;

   // Internal wide format for range reduction.
   localparam int WIDE_W    = 64;
   localparam int WIDE_FRAC = 56;

   // Polynomial arithmetic format.
   localparam int Q30_FRAC = 30;
   localparam int R_SHIFT  = WIDE_FRAC - Q30_FRAC;

   // Widths of the intermediate values of the polynomial.
   localparam int R_W      = 32;
   localparam int X2_W     = 33;
   localparam int T_W      = 32;
   localparam int U_W      = 32;
   localparam int Y_W      = 32;
   localparam int SINE_W   = 32;
   localparam int COEF_A_W = 24;

   // The multiple of pi is held as an offset code kc, with k = kc - K_OFFSET.
   localparam int KC_W         = 4;
   localparam int K_OFFSET     = 5;
   localparam int K_LEVELS     = 11;
   localparam int K_THRESHOLDS = K_LEVELS - 1;

   // pi and pi/2 in Q.56, rounded to nearest.
   localparam logic signed [WIDE_W-1:0] PI_Q56      = 64'sh03243F6A8885A309;
   localparam logic signed [WIDE_W-1:0] HALF_PI_Q56 = 64'sh01921FB54442D184;

   // Polynomial coefficients in Q.30.
   localparam logic signed [COEF_A_W-1:0] COEF_A = 24'sd7894653;
   localparam logic signed [T_W-1:0]      COEF_B = -32'sd177477835;
   localparam logic signed [U_W-1:0]      COEF_C = 32'sd1073411097;

   // Plus one in Q1.30, the saturation bound of the result.
   localparam logic signed [SINE_W-1:0] ONE_Q30 = 32'sd1073741824;

   // Lower bound of the angle for which k reaches a given level.
   function automatic logic signed [WIDE_W-1:0] k_threshold(input int j);
      return WIDE_W'(j + 1 - K_OFFSET) * PI_Q56 - HALF_PI_Q56;
   endfunction

   // k * pi in Q.56 for an offset code kc.
   function automatic logic signed [WIDE_W-1:0] k_times_pi(input logic [KC_W-1:0] kc);
      logic signed [WIDE_W-1:0] result;
      result = '0;
      for (int j = 0; j < K_LEVELS; j++) begin
         if (kc == KC_W'(j)) begin
            result = WIDE_W'(j - K_OFFSET) * PI_Q56;
         end
      end
      return result;
   endfunction

   // Round a Q.60 product to Q.30, half toward plus infinity.
   function automatic logic signed [WIDE_W-1:0] round_q30(input logic signed [WIDE_W-1:0] p);
      logic signed [WIDE_W-1:0] half;
      half = WIDE_W'(1) <<< (Q30_FRAC - 1);
      return (p + half) >>> Q30_FRAC;
   endfunction

endpackage

/* hdl/sine_polynomial_approximation_unit.sv */
// ----------------------------------------------------------------------------
// Sine polynomial approximation unit
// Odd quintic polynomial approximation of sin(angle) in fixed point.
// ----------------------------------------------------------------------------
// The unit accepts one signed angle in radians per clock while the result side
// is ready (Q4.27 at the default 32-bit width) and returns sin(angle) as signed
// Q1.30, limited to plus or minus one. Each request passes through a seven-stage
// pipeline: the nearest multiple of pi is found by parallel threshold compares,
// the angle is reduced to [-pi/2, pi/2), four multiply-round-add stages
// evaluate the polynomial, and a final stage applies the sign of the odd
// multiple and saturates. The request is registered in stages 1 and 2, the four
// multiply stages and the output stage. Sustained throughput is one request per
// cycle while the result side is ready, set by the multiplier stages, which
// each start a new product every clock. A stall on the result side reaches
// back through the combinational ready chain in the same cycle, and empty
// stages still fill while the output waits.
// ----------------------------------------------------------------------------
module sine_polynomial_approximation_unit
   import spa_pkg::*;
#(
   parameter int ANGLE_WIDTH = DEFAULT_ANGLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SINE_W-1:0]      rsp_sine_value
);

   // Left shift that widens the angle fraction to Q.56.
   localparam int SHIFT = WIDE_FRAC - (ANGLE_WIDTH - ANGLE_INT_BITS);

   localparam int M1_SIDE_W = 1 + R_W;
   localparam int M2_SIDE_W = 1 + R_W + X2_W;
   localparam int M3_SIDE_W = 1 + R_W;
   localparam int M4_SIDE_W = 1;

   // Stage 1: multiple of pi.
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic                          s1_ready;
   logic signed [ANGLE_WIDTH-1:0] s1_angle_ff;
   logic [KC_W-1:0]               s1_kc_ff;
   logic [KC_W-1:0]               s1_kc_in;
   logic signed [WIDE_W-1:0]      s1_wide;

   // Stage 2: reduced angle.
   logic                     s2_valid_ff;
   logic                     s2_valid_in;
   logic                     s2_ready;
   logic signed [R_W-1:0]    s2_r_ff;
   logic signed [R_W-1:0]    s2_r_in;
   logic                     s2_odd_ff;
   logic signed [WIDE_W-1:0] s2_wide;
   logic signed [WIDE_W-1:0] s2_diff;
   logic signed [WIDE_W-1:0] s2_round;

   // Polynomial stages.
   logic                   m1_in_ready;
   logic                   m1_valid;
   logic signed [X2_W-1:0] m1_x2;
   logic [M1_SIDE_W-1:0]   m1_side;
   logic                   m1_odd;
   logic signed [R_W-1:0]  m1_r;

   logic                   m2_in_ready;
   logic                   m2_valid;
   logic signed [T_W-1:0]  m2_t;
   logic [M2_SIDE_W-1:0]   m2_side;
   logic                   m2_odd;
   logic signed [R_W-1:0]  m2_r;
   logic signed [X2_W-1:0] m2_x2;

   logic                   m3_in_ready;
   logic                   m3_valid;
   logic signed [U_W-1:0]  m3_u;
   logic [M3_SIDE_W-1:0]   m3_side;
   logic                   m3_odd;
   logic signed [R_W-1:0]  m3_r;

   logic                   m4_in_ready;
   logic                   m4_valid;
   logic signed [Y_W-1:0]  m4_y;
   logic [M4_SIDE_W-1:0]   m4_side;

   // Output stage.
   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic                      out_ready;
   logic signed [SINE_W-1:0]  out_value_ff;
   logic signed [SINE_W-1:0]  out_value_in;
   logic signed [Y_W:0]       y_signed;

   // ---------------------------------------------------------------- stage 1
   // Count the thresholds that the widened angle reaches to get k + offset.
   assign s1_wide = WIDE_W'(req_angle) <<< SHIFT;

   always_comb begin
      s1_kc_in = '0;
      for (int j = 0; j < K_THRESHOLDS; j++) begin
         if (s1_wide >= k_threshold(j)) begin
            s1_kc_in = s1_kc_in + KC_W'(1);
         end
      end
   end

   assign s1_ready    = !s1_valid_ff || s2_ready;
   assign req_ready   = s1_ready;
   assign s1_valid_in = s1_ready ? req_valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s1_ready) begin
         s1_angle_ff <= req_angle;
         s1_kc_ff    <= s1_kc_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Subtract k * pi and round the remainder from Q.56 to Q.30.
   assign s2_wide  = WIDE_W'(s1_angle_ff) <<< SHIFT;
   assign s2_diff  = s2_wide - k_times_pi(s1_kc_ff);
   assign s2_round = (s2_diff + (WIDE_W'(1) <<< (R_SHIFT - 1))) >>> R_SHIFT;
   assign s2_r_in  = s2_round[R_W-1:0];

   assign s2_ready    = !s2_valid_ff || m1_in_ready;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   // An odd k has an even offset code.
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_r_ff   <= s2_r_in;
         s2_odd_ff <= ~s1_kc_ff[0];
      end
   end

   // ---------------------------------------------------------- stages 3 to 6
   // x2 = r * r
   spa_mul_add #(
      .OP_A_W (R_W),
      .OP_B_W (R_W),
      .RES_W  (X2_W),
      .SIDE_W (M1_SIDE_W)
   ) u_mul_x2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (m1_in_ready),
      .op_a      (s2_r_ff),
      .op_b      (s2_r_ff),
      .addend    ('0),
      .side_in   ({s2_odd_ff, s2_r_ff}),
      .out_valid (m1_valid),
      .out_ready (m2_in_ready),
      .result    (m1_x2),
      .side_out  (m1_side)
   );

   assign {m1_odd, m1_r} = m1_side;

   // t = b + a * x2
   spa_mul_add #(
      .OP_A_W (COEF_A_W),
      .OP_B_W (X2_W),
      .RES_W  (T_W),
      .SIDE_W (M2_SIDE_W)
   ) u_mul_t (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m1_valid),
      .in_ready  (m2_in_ready),
      .op_a      (COEF_A),
      .op_b      (m1_x2),
      .addend    (COEF_B),
      .side_in   ({m1_odd, m1_r, m1_x2}),
      .out_valid (m2_valid),
      .out_ready (m3_in_ready),
      .result    (m2_t),
      .side_out  (m2_side)
   );

   assign {m2_odd, m2_r, m2_x2} = m2_side;

   // u = c + x2 * t
   spa_mul_add #(
      .OP_A_W (X2_W),
      .OP_B_W (T_W),
      .RES_W  (U_W),
      .SIDE_W (M3_SIDE_W)
   ) u_mul_u (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_valid),
      .in_ready  (m3_in_ready),
      .op_a      (m2_x2),
      .op_b      (m2_t),
      .addend    (COEF_C),
      .side_in   ({m2_odd, m2_r}),
      .out_valid (m3_valid),
      .out_ready (m4_in_ready),
      .result    (m3_u),
      .side_out  (m3_side)
   );

   assign {m3_odd, m3_r} = m3_side;

   // y = r * u
   spa_mul_add #(
      .OP_A_W (R_W),
      .OP_B_W (U_W),
      .RES_W  (Y_W),
      .SIDE_W (M4_SIDE_W)
   ) u_mul_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m3_valid),
      .in_ready  (m4_in_ready),
      .op_a      (m3_r),
      .op_b      (m3_u),
      .addend    ('0),
      .side_in   (m3_odd),
      .out_valid (m4_valid),
      .out_ready (out_ready),
      .result    (m4_y),
      .side_out  (m4_side)
   );

   // ---------------------------------------------------------------- stage 7
   // Negate for an odd multiple of pi, then limit to plus or minus one.
   always_comb begin
      y_signed = m4_side[0] ? -(Y_W + 1)'(m4_y) : (Y_W + 1)'(m4_y);
      if (y_signed > (Y_W + 1)'(ONE_Q30)) begin
         out_value_in = ONE_Q30;
      end else if (y_signed < -(Y_W + 1)'(ONE_Q30)) begin
         out_value_in = -ONE_Q30;
      end else begin
         out_value_in = y_signed[SINE_W-1:0];
      end
   end

   assign out_ready    = !out_valid_ff || rsp_ready;
   assign out_valid_in = out_ready ? m4_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m4_valid && out_ready) begin
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sine_value = out_value_ff;

endmodule

/* hdl/spa_mul_add.sv */
// ----------------------------------------------------------------------------
// Multiply, round and add pipeline stage
// Computes addend + round(op_a * op_b / 2^30) into a register, with a
// valid/ready handshake and a sideband that travels alongside the data.
// ----------------------------------------------------------------------------
module spa_mul_add
   import spa_pkg::*;
#(
   parameter int OP_A_W = R_W,
   parameter int OP_B_W = R_W,
   parameter int RES_W  = R_W,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [OP_A_W-1:0] op_a,
   input  logic signed [OP_B_W-1:0] op_b,
   input  logic signed [RES_W-1:0]  addend,
   input  logic [SIDE_W-1:0]        side_in,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [RES_W-1:0]  result,
   output logic [SIDE_W-1:0]        side_out
);

   logic                    valid_ff;
   logic                    valid_in;
   logic signed [RES_W-1:0] result_ff;
   logic signed [RES_W-1:0] result_in;
   logic [SIDE_W-1:0]       side_ff;
   logic signed [WIDE_W-1:0] product;
   logic signed [WIDE_W-1:0] sum;
   logic                    load;

   // The stage takes a new request when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Signed product, rounded back to Q.30, plus the addend.
   assign product   = WIDE_W'(op_a) * WIDE_W'(op_b);
   assign sum       = WIDE_W'(addend) + round_q30(product);
   assign result_in = sum[RES_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers load only with a new request.
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
         side_ff   <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign result    = result_ff;
   assign side_out  = side_ff;

endmodule

/* hdl/spa_checker.sv */
// ----------------------------------------------------------------------------
// Sine polynomial approximation checker
// Port-level assertions for the sine unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module spa_checker
   import spa_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [SINE_W-1:0] rsp_sine_value
);

   // Every delivered sine lies within plus or minus one.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sine_value <= ONE_Q30 && rsp_sine_value >= -ONE_Q30))
      else $error("sine result outside plus or minus one");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the result side ready, every stage can advance, so a request is taken.
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side stalled while result side is ready");

   // A stalled result stays valid and unchanged.
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sine_value))
      else $error("stalled result dropped or changed");

endmodule

bind sine_polynomial_approximation_unit spa_checker u_spa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sine_value (rsp_sine_value)
);

/* test/sine_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sine result checker
// Watches the request and result channels of the sine unit, predicts the
// sine of every accepted angle in fixed point and compares each result with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sine_result_checker
   import spa_pkg::*;
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [DEFAULT_ANGLE_WIDTH-1:0] req_angle,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [SINE_W-1:0]              rsp_sine_value,
   output int                                    mismatch_count,
   output int                                    pending_count
);

   localparam int ANGLE_W    = DEFAULT_ANGLE_WIDTH;
   // Left shift that widens the angle fraction to the Q.56 format.
   localparam int FRAC_SHIFT = WIDE_FRAC - (ANGLE_W - ANGLE_INT_BITS);

   typedef struct {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [SINE_W-1:0]  sine;
   } sine_request_type;

   // Sines predicted for accepted requests, oldest first.
   sine_request_type expected_sines[$];

   // Drop s fraction bits, rounding half toward plus infinity.
   function automatic longint rounded_shift(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // Fixed-point sine: reduce by the nearest multiple of pi, evaluate the odd
   // quintic in Q.30, flip the sign for odd multiples and saturate to one.
   function automatic logic signed [SINE_W-1:0] predict_sine(
      input logic signed [ANGLE_W-1:0] angle);
      longint wide, shifted, turns, reduced, x2, t, u, y;
      wide    = longint'(angle) * (longint'(1) <<< FRAC_SHIFT);
      shifted = wide + longint'(HALF_PI_Q56);
      // Integer division truncates, so correct it to a floor.
      turns = shifted / longint'(PI_Q56);
      if (shifted < 0 && turns * longint'(PI_Q56) != shifted) begin
         turns = turns - 1;
      end
      reduced = rounded_shift(wide - turns * longint'(PI_Q56), WIDE_FRAC - Q30_FRAC);
      x2 = rounded_shift(reduced * reduced, Q30_FRAC);
      t  = longint'(COEF_B) + rounded_shift(longint'(COEF_A) * x2, Q30_FRAC);
      u  = longint'(COEF_C) + rounded_shift(x2 * t, Q30_FRAC);
      y  = rounded_shift(reduced * u, Q30_FRAC);
      if (turns[0]) begin
         y = -y;
      end
      if (y > longint'(ONE_Q30)) begin
         y = longint'(ONE_Q30);
      end
      if (y < -longint'(ONE_Q30)) begin
         y = -longint'(ONE_Q30);
      end
      return y[SINE_W-1:0];
   endfunction

   // Compare results first, then record the new request, so that a result
   // can never match a request accepted at the same edge.
   always @(posedge clock) begin
      sine_request_type oldest;
      if (reset) begin
         expected_sines.delete();
         mismatch_count <= 0;
         pending_count  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sines.size() == 0) begin
               $display("%0t: unexpected sine result, expected none, actual %0d",
                        $time, rsp_sine_value);
               mismatch_count <= mismatch_count + 1;
            end else begin
               oldest = expected_sines.pop_front();
               if (rsp_sine_value !== oldest.sine) begin
                  $display("%0t: sine of angle %h, expected %0d, actual %0d",
                           $time, oldest.angle, oldest.sine, rsp_sine_value);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_sines.push_back('{req_angle, predict_sine(req_angle)});
         end
         pending_count <= expected_sines.size();
      end
   end

endmodule

/* test/sine_polynomial_approximation_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sine polynomial approximation unit test
// Drives angles into the sine unit, directed around the extremes and the
// half multiples of pi first and at random afterwards, with random gaps on
// the request side and random stalls on the result side. A checker beside
// the unit predicts and compares every result.
// ----------------------------------------------------------------------------
module sine_polynomial_approximation_unit_test
   import spa_pkg::*;
();

   localparam int ANGLE_W        = DEFAULT_ANGLE_WIDTH;
   localparam int FRAC_SHIFT     = WIDE_FRAC - (ANGLE_W - ANGLE_INT_BITS);
   localparam int RANDOM_ANGLES  = 600;
   localparam int MAX_WAIT       = 18;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [ANGLE_W-1:0] req_angle = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SINE_W-1:0]  rsp_sine_value;
   int                        mismatch_count;
   int                        pending_count;
   int                        idle_cycles = 0;
   bit                        req_busy = 1'b1;
   bit                        rsp_busy = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sine_polynomial_approximation_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_angle      (req_angle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sine_value (rsp_sine_value)
   );

   sine_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_angle      (req_angle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sine_value (rsp_sine_value),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Wait before an item: none in a calm stretch, random in a busy one.
   function automatic int draw_wait(input bit busy);
      return busy ? int'($urandom_range(0, MAX_WAIT)) : 0;
   endfunction

   // Angle code just below m * pi/2, rounded toward minus infinity.
   function automatic logic signed [ANGLE_W-1:0] half_pi_code(input int m);
      longint wide;
      wide = longint'(m) * longint'(HALF_PI_Q56);
      return ANGLE_W'(wide >>> FRAC_SHIFT);
   endfunction

   // Send one request, idling first when the request side is busy.
   task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
      int gap;
      if ($urandom_range(0, 15) == 0) begin
         req_busy = !req_busy;
      end
      gap = draw_wait(req_busy);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_angle <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle <= angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Random angle, weighted toward the points where the reduction turns over.
   function automatic logic signed [ANGLE_W-1:0] random_angle();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         return $urandom;
      end else if (pick < 8) begin
         return half_pi_code(2 * $urandom_range(0, 9) - 9) + $urandom_range(0, 64) - 32;
      end else if (pick < 9) begin
         return half_pi_code(2 * $urandom_range(0, 10) - 10) + $urandom_range(0, 64) - 32;
      end
      return ANGLE_W'($signed(16'($urandom)));
   endfunction

   // Result side: before each result, stall for a random wait in a busy stretch, none in a calm one.
   initial begin
      int stall;
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rsp_busy = !rsp_busy;
         end
         stall = draw_wait(rsp_busy);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Watchdog: end the run when no request or result moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      logic signed [ANGLE_W-1:0] directed_angles[$];
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Zero, the extremes of the angle code, and plus and minus pi.
      directed_angles.push_back('0);
      directed_angles.push_back({1'b1, {(ANGLE_W - 1){1'b0}}});
      directed_angles.push_back({1'b0, {(ANGLE_W - 1){1'b1}}});
      directed_angles.push_back(half_pi_code(2));
      directed_angles.push_back(half_pi_code(-2));
      // Both sides of every odd multiple of pi/2 in range, where the multiple
      // of pi changes and the polynomial may overshoot one.
      for (int m = -9; m <= 9; m += 2) begin
         directed_angles.push_back(half_pi_code(m));
         directed_angles.push_back(half_pi_code(m) + 1);
      end
      foreach (directed_angles[i]) begin
         send_angle(directed_angles[i]);
      end

      for (int i = 0; i < RANDOM_ANGLES; i++) begin
         send_angle(random_angle());
      end
      req_valid <= 1'b0;

      // One more edge so that the count includes the last request.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/spa_pkg.sv
hdl/spa_mul_add.sv
hdl/sine_polynomial_approximation_unit.sv
hdl/spa_checker.sv
test/sine_result_checker.sv
test/sine_polynomial_approximation_unit_test.sv
